@@ rtl/vnu_pkg.sv @@
// Shared widths, constants and payload types of the vector norm unit.
package vnu_pkg;

  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned SQR_W       = 31;
  localparam int unsigned ONE_NORM_W  = 26;
  localparam int unsigned SQ_SUM_W    = 41;
  localparam int unsigned TWO_NORM_W  = 21;
  localparam int unsigned MAX_NORM_W  = 16;
  localparam int unsigned COUNT_W     = 11;

  // Square root chain: two radicand bits enter each step.
  localparam int unsigned RAD_W       = 42;
  localparam int unsigned ROOT_W      = TWO_NORM_W;
  localparam int unsigned REM_W       = ROOT_W + 1;
  localparam int unsigned SQRT_STEPS  = RAD_W / 2;

  localparam int unsigned MAX_LEN_DEF = 1024;

  typedef struct packed {
    logic [ONE_NORM_W-1:0] one_norm;
    logic [MAX_NORM_W-1:0] max_norm;
    logic [COUNT_W-1:0]    element_count;
    logic                  saturated;
  } vnu_res_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    vnu_res_t          res;
  } vnu_cell_t;

endpackage

@@ rtl/vnu_ifs.sv @@
// Valid/ready channel interfaces for element requests and norm results.
interface vnu_in_if import vnu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;
  logic                     last_element;

  modport source (output valid, element_value, last_element, input ready);
  modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface vnu_out_if import vnu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ONE_NORM_W-1:0] one_norm;
  logic [TWO_NORM_W-1:0] two_norm;
  logic [MAX_NORM_W-1:0] max_norm;
  logic [COUNT_W-1:0]    element_count;
  logic                  saturated;

  modport source (output valid, one_norm, two_norm, max_norm, element_count, saturated,
                  input ready);
  modport sink   (input valid, one_norm, two_norm, max_norm, element_count, saturated,
                  output ready);
endinterface

@@ rtl/vnu_acc.sv @@
// Element accumulator: magnitude and square stage, then saturating running sums.
module vnu_acc import vnu_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic                     last_element_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output vnu_cell_t                out_data_o
);

  localparam logic [63:0] LenL     = 64'(MAX_LEN);
  localparam logic [63:0] CountLim = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [63:0] AbsLim   = (64'd1 << ONE_NORM_W) - 64'd1;
  localparam logic [63:0] SqLim    = (64'd1 << SQ_SUM_W) - 64'd1;
  localparam logic [63:0] AbsFull  = LenL << (ELEM_W - 1);
  localparam logic [63:0] SqFull   = LenL << (2 * (ELEM_W - 1));
  localparam logic [COUNT_W-1:0]    CountCap = COUNT_W'((LenL < CountLim) ? LenL : CountLim);
  localparam logic [ONE_NORM_W-1:0] AbsCap   = ONE_NORM_W'((AbsFull < AbsLim) ? AbsFull : AbsLim);
  localparam logic [SQ_SUM_W-1:0]   SqCap    = SQ_SUM_W'((SqFull < SqLim) ? SqFull : SqLim);

  logic [ELEM_W-1:0]      raw;
  logic [MAG_W-1:0]       mag_d, mag_q;
  logic [SQR_W-1:0]       sqr_d, sqr_q;
  logic                   s1_valid_q, s1_last_q;
  logic                   s1_adv, s1_fire;

  logic [ONE_NORM_W-1:0]  abs_q, abs_d;
  logic [SQ_SUM_W-1:0]    sq_q, sq_d;
  logic [MAX_NORM_W-1:0]  max_q, max_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic                   cnt_full;
  logic [ONE_NORM_W:0]    abs_wide;
  logic [SQ_SUM_W:0]      sq_wide;

  // Magnitude of a two's complement value; the most negative one maps to 2^15.
  assign raw   = element_value_i;
  assign mag_d = raw[ELEM_W-1] ? MAG_W'(~raw + 16'd1) : raw;
  assign sqr_d = SQR_W'(mag_d) * SQR_W'(mag_d);

  // Hold the stage only when a last element waits for the root chain.
  assign s1_adv      = !s1_valid_q || !s1_last_q || out_ready_i;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign in_ready_o  = s1_adv;
  assign out_valid_o = s1_valid_q && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
      s1_last_q  <= last_element_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      mag_q <= mag_d;
      sqr_q <= sqr_d;
    end
  end

  always_comb begin
    cnt_full = (count_q >= CountCap);
    count_d  = cnt_full ? count_q : count_q + 1'b1;
    ovf_d    = ovf_q | cnt_full;
    abs_wide = {1'b0, abs_q} + (ONE_NORM_W + 1)'(mag_q);
    abs_d    = (abs_wide > {1'b0, AbsCap}) ? AbsCap : abs_wide[ONE_NORM_W-1:0];
    sq_wide  = {1'b0, sq_q} + (SQ_SUM_W + 1)'(sqr_q);
    sq_d     = (sq_wide > {1'b0, SqCap}) ? SqCap : sq_wide[SQ_SUM_W-1:0];
    max_d    = (mag_q > max_q) ? mag_q : max_q;
  end

  always_comb begin
    out_data_o                   = '0;
    out_data_o.rad               = RAD_W'(sq_d);
    out_data_o.res.one_norm      = abs_d;
    out_data_o.res.max_norm      = max_d;
    out_data_o.res.element_count = count_d;
    out_data_o.res.saturated     = ovf_d;
  end

  // Clear everything once a vector's result leaves for the root chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q   <= '0;
      sq_q    <= '0;
      max_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        abs_q   <= '0;
        sq_q    <= '0;
        max_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        abs_q   <= abs_d;
        sq_q    <= sq_d;
        max_q   <= max_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountCap) else $error("element count beyond cap");
  a_ovf_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == CountCap) else $error("overflow flag below cap");
  a_sums_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    abs_q <= AbsCap && sq_q <= SqCap) else $error("running sum beyond cap");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> count_q == '0 && !ovf_q && max_q == '0)
    else $error("state not cleared after last element");
`endif

endmodule

@@ rtl/vnu_sqrt_cell.sv @@
// One digit step of the square root chain, with its own valid/ready slot.
module vnu_sqrt_cell import vnu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  vnu_cell_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vnu_cell_t out_data_o
);

  logic              valid_q;
  vnu_cell_t         data_q, data_d;
  logic [REM_W+1:0]  rem_sh, trial, diff;
  logic              ge;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Shift in two radicand bits, try subtracting 4*root+1.
  always_comb begin
    rem_sh      = {in_data_i.rem, in_data_i.rad[RAD_W-1 -: 2]};
    trial       = {1'b0, in_data_i.root, 2'b01};
    ge          = (rem_sh >= trial);
    diff        = rem_sh - trial;
    data_d      = in_data_i;
    data_d.rad  = in_data_i.rad << 2;
    data_d.rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    data_d.root = {in_data_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

@@ rtl/vector_norm_unit.sv @@
// Top level of the vector norm unit: accumulator followed by the square root chain.
//
// Usage: vector elements arrive on in_i, one signed Q8.8 value per request, with
// last_element high on the final element of each vector. For every vector the
// block sends one result request on out_o holding the one-norm (saturating sum
// of magnitudes), the two-norm (floor square root of the sum of squares, Q13.8),
// the max-norm, the element count and a saturation flag.
// Throughput: one element per cycle, set by the single accumulate step each element
// takes, unless a last element waits for the chain; the accumulator clears in the
// same cycle the last element leaves it, so the next vector follows without a gap.
// A last element is registered in the magnitude and square stage, where the
// running sums close and feed the first cell of the 21-cell root chain; the
// result then passes through the remaining cells, one radicand digit pair per
// cell.
// The chain takes a new vector result every cycle unless the receiver stalls, so it
// overlaps the accumulation of later vectors.
// Reset (rst_ni low, asynchronous): all sums, counts and cell valid bits clear.
// Receiver stall: the finished result holds in the last cell; earlier cells keep
// filling empty slots, and in_i.ready drops only when a last element finds the
// whole chain occupied.
module vector_norm_unit import vnu_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  vnu_in_if.sink    in_i,
  vnu_out_if.source out_o
);

  logic      cell_valid [SQRT_STEPS+1];
  logic      cell_ready [SQRT_STEPS+1];
  vnu_cell_t cell_data  [SQRT_STEPS+1];

  // Accumulate elements; emit one request per vector into the chain.
  vnu_acc #(
    .MAX_LEN (MAX_LEN)
  ) u_acc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .element_value_i (in_i.element_value),
    .last_element_i  (in_i.last_element),
    .out_valid_o     (cell_valid[0]),
    .out_ready_i     (cell_ready[0]),
    .out_data_o      (cell_data[0])
  );

  // Root chain: each cell resolves one bit of the two-norm and passes it on.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
    vnu_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_valid[k]),
      .in_ready_o  (cell_ready[k]),
      .in_data_i   (cell_data[k]),
      .out_valid_o (cell_valid[k+1]),
      .out_ready_i (cell_ready[k+1]),
      .out_data_o  (cell_data[k+1])
    );
  end

  // The last cell doubles as the output register.
  assign cell_ready[SQRT_STEPS] = out_o.ready;
  assign out_o.valid            = cell_valid[SQRT_STEPS];
  assign out_o.one_norm         = cell_data[SQRT_STEPS].res.one_norm;
  assign out_o.two_norm         = cell_data[SQRT_STEPS].root;
  assign out_o.max_norm         = cell_data[SQRT_STEPS].res.max_norm;
  assign out_o.element_count    = cell_data[SQRT_STEPS].res.element_count;
  assign out_o.saturated        = cell_data[SQRT_STEPS].res.saturated;

endmodule
